// ===== rtl/pewc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pewc_pkg: shared constants for the polygon centroid unit
// Widths of coordinates, accumulators and configuration registers.
// ----------------------------------------------------------------------------
package pewc_pkg;
  localparam int COORD_W = 24;
  localparam int ASPECT_W = 20;
  localparam int SCALED_W = 28;
  localparam int SUM_W = 64;
  localparam int WEIGHT_W = 48;
  localparam int DEF_MAX_VERTICES = 1024;
  localparam int FRACTION_BITS = 16;
  localparam logic [ASPECT_W-1:0] ASPECT_RESET = ASPECT_W'(1 << FRACTION_BITS);
  localparam logic [0:0] REG_ASPECT_U = 1'b0;
  localparam logic [0:0] REG_ASPECT_V = 1'b1;
endpackage
`default_nettype wire

// ===== rtl/pewc_isqrt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pewc_isqrt: iterative integer square root
// One result bit per cycle for a 64-bit radicand.
// ----------------------------------------------------------------------------
module pewc_isqrt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] radicand,
  output logic             done,
  output logic [31:0]      root
);
  logic [63:0] rem, rt, bitv;
  logic busy;
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem  <= radicand;
        rt   <= '0;
        bitv <= 64'h4000_0000_0000_0000;
      end else if (busy) begin
        if (rem >= rt + bitv) begin
          rem <= rem - (rt + bitv);
          rt  <= (rt >> 1) + bitv;
        end else begin
          rt <= rt >> 1;
        end
        bitv <= bitv >> 2;
        if (bitv == 64'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign root = rt[31:0];
endmodule
`default_nettype wire

// ===== rtl/pewc_divider.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pewc_divider: signed restoring divider, one quotient bit per cycle
// Truncates toward zero; 64-bit dividend, 48-bit unsigned divisor.
// ----------------------------------------------------------------------------
module pewc_divider (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [63:0] dividend,
  input  wire logic [47:0]        divisor,
  output logic                    done,
  output logic signed [64:0]      quotient
);
  logic [64:0] mag, quo;
  logic [48:0] rem;
  logic [47:0] dvs;
  logic neg, busy;
  logic [6:0] cnt;
  logic [48:0] trial;
  always_comb trial = {rem[47:0], mag[64]};
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        neg  <= dividend[63];
        mag  <= dividend[63] ? 65'(-{dividend[63], dividend}) : {1'b0, dividend};
        rem  <= '0;
        dvs  <= divisor;
        cnt  <= 7'd0;
      end else if (busy) begin
        mag <= mag << 1;
        if (trial >= {1'b0, dvs}) begin
          rem <= trial - {1'b0, dvs};
          quo <= {quo[63:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[63:0], 1'b0};
        end
        cnt <= cnt + 7'd1;
        if (cnt == 7'd64) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign quotient = neg ? -$signed(quo) : $signed(quo);
endmodule
`default_nettype wire

// ===== rtl/polygon_edge_weighted_centroid_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// polygon_edge_weighted_centroid_unit: edge-length weighted polygon center
// Vertices arrive in ring order; one result per ring on the last vertex.
// ----------------------------------------------------------------------------
// A vertex request runs two scaling multiplies, two squaring steps, a
// 32-step square root with its start and wait states, and two
// multiply-accumulate steps per axis. The first vertex of a ring has no
// edge yet. The last vertex adds the closing edge and four passes through
// the 65-step serial divider (mean u, center u, mean v, center v); with
// zero total weight the divider is skipped.
// The block takes no request while busy; the result is loaded into an output
// register and a new ring may start while it waits there. If an earlier
// result is still untaken, the block holds in its final step until it is.
module polygon_edge_weighted_centroid_unit #(
  parameter int MAX_FACE_VERTICES = pewc_pkg::DEF_MAX_VERTICES
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,  // coord_u[23:0], coord_v[47:24]
  input  wire logic        s_tlast,  // last_vertex
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,  // center_u[23:0], center_v[47:24]
  output logic             m_tuser,  // degenerate
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [19:0] cfg_data
);
  import pewc_pkg::*;

  localparam int CNT_W = $clog2(MAX_FACE_VERTICES + 1);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_SQ    = 11'b00000000010,
    S_ROOT  = 11'b00000000100,
    S_WAIT  = 11'b00000001000,
    S_ACCU  = 11'b00000010000,
    S_ACCV  = 11'b00000100000,
    S_DIV   = 11'b00001000000,
    S_DWAIT = 11'b00010000000,
    S_DONE  = 11'b00100000000,
    S_OUT   = 11'b01000000000,
    S_SCALE = 11'b10000000000
  } state_t;
  state_t state;

  logic [ASPECT_W-1:0] aspect_u, aspect_v;
  logic signed [SCALED_W-1:0] first_u, first_v, previous_u, previous_v, cur_u, cur_v;
  logic signed [SCALED_W-1:0] a_u, a_v, b_u, b_v;
  logic signed [SUM_W-1:0] wsum_u, wsum_v;
  logic [WEIGHT_W-1:0] total_weight;
  logic [CNT_W-1:0] vertex_count;
  logic last, closing;
  logic signed [COORD_W-1:0] in_u, in_v;
  logic signed [63:0] sq_acc;
  logic [1:0] phase; // divide passes: mean u, center u, mean v, center v
  logic [31:0] len;
  logic signed [COORD_W-1:0] out_u, out_v;
  logic deg; // zero total weight, goes out with the result

  // shared multiplier: signed 33 x 33
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  assign mul_p = mul_a * mul_b;

  logic signed [SCALED_W:0] du, dv;
  assign du = (SCALED_W+1)'(a_u) - (SCALED_W+1)'(b_u);
  assign dv = (SCALED_W+1)'(a_v) - (SCALED_W+1)'(b_v);

  logic root_start, root_done;
  logic [31:0] root;
  pewc_isqrt u_root (.clk, .rst, .start(root_start), .radicand(sq_acc),
                     .done(root_done), .root);

  logic div_start, div_done;
  logic signed [63:0] div_n;
  logic [47:0] div_d;
  logic signed [64:0] div_q;
  pewc_divider u_div (.clk, .rst, .start(div_start), .dividend(div_n),
                      .divisor(div_d), .done(div_done), .quotient(div_q));

  logic step; // sub-step within a state
  logic signed [SUM_W-1:0] prod_reg;
  logic signed [SUM_W:0] sat_sum;
  logic signed [SUM_W-1:0] acc_sel;
  logic signed [64:0] mean_c, cen_c;
  logic [ASPECT_W-1:0] asp_sel;

  function automatic logic signed [SUM_W-1:0] sat_of(input logic signed [SUM_W:0] x);
    if (x[SUM_W] != x[SUM_W-1])
      return x[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    return x[SUM_W-1:0];
  endfunction

  assign acc_sel = (state == S_ACCU) ? wsum_u : wsum_v;
  assign sat_sum = {acc_sel[SUM_W-1], acc_sel} + {prod_reg[SUM_W-1], prod_reg};
  assign asp_sel = phase[1] ? aspect_v : aspect_u;

  always_comb begin
    mean_c = div_q;
    if (div_q > 65'sd68719476736) mean_c = 65'sd68719476736;
    if (div_q < -65'sd68719476736) mean_c = -65'sd68719476736;
    cen_c = div_q;
    if (div_q > 65'sd8388607) cen_c = 65'sd8388607;
    if (div_q < -65'sd8388608) cen_c = -65'sd8388608;
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_SCALE: begin
        mul_a = step ? 33'(in_v) : 33'(in_u);
        mul_b = step ? 33'({1'b0, aspect_v}) : 33'({1'b0, aspect_u});
      end
      S_SQ: begin
        mul_a = step ? 33'(dv) : 33'(du);
        mul_b = mul_a;
      end
      S_ACCU: begin
        mul_a = {1'b0, len};
        mul_b = 33'(a_u) + 33'(b_u);
      end
      S_ACCV: begin
        mul_a = {1'b0, len};
        mul_b = 33'(a_v) + 33'(b_v);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  logic [WEIGHT_W:0] wsum;
  assign wsum = {1'b0, total_weight} + {16'd0, len, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      aspect_u <= ASPECT_RESET;
      aspect_v <= ASPECT_RESET;
      m_tvalid <= 1'b0;
      vertex_count <= '0;
      first_u <= '0; first_v <= '0; previous_u <= '0; previous_v <= '0;
      wsum_u <= '0; wsum_v <= '0; total_weight <= '0;
      root_start <= 1'b0;
      div_start <= 1'b0;
    end else begin
      root_start <= 1'b0;
      div_start <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == REG_ASPECT_U) aspect_u <= cfg_data;
        else aspect_v <= cfg_data;
      end
      // S_OUT reloads the register itself when the old result leaves
      if (m_tvalid && m_tready && state != S_OUT) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            in_u <= s_tdata[23:0];
            in_v <= s_tdata[47:24];
            last <= s_tlast;
            step <= 1'b0;
            state <= S_SCALE;
          end
        end
        S_SCALE: begin
          // arithmetic shift is a floor
          if (!step) begin
            cur_u <= SCALED_W'(mul_p >>> FRACTION_BITS);
            step <= 1'b1;
          end else begin
            cur_v <= SCALED_W'(mul_p >>> FRACTION_BITS);
            step <= 1'b0;
            if (vertex_count < CNT_W'(MAX_FACE_VERTICES))
              vertex_count <= vertex_count + CNT_W'(1);
            previous_u <= cur_u;
            previous_v <= SCALED_W'(mul_p >>> FRACTION_BITS);
            if (vertex_count == '0) begin
              first_u <= cur_u;
              first_v <= SCALED_W'(mul_p >>> FRACTION_BITS);
              if (last) begin
                a_u <= cur_u; a_v <= SCALED_W'(mul_p >>> FRACTION_BITS);
                b_u <= cur_u; b_v <= SCALED_W'(mul_p >>> FRACTION_BITS);
                closing <= 1'b1;
                state <= S_SQ;
              end else begin
                state <= S_IDLE;
              end
            end else begin
              a_u <= previous_u; a_v <= previous_v;
              b_u <= cur_u; b_v <= SCALED_W'(mul_p >>> FRACTION_BITS);
              closing <= 1'b0;
              state <= S_SQ;
            end
          end
        end
        S_SQ: begin
          if (!step) begin
            sq_acc <= mul_p[63:0];
            step <= 1'b1;
          end else begin
            sq_acc <= sq_acc + mul_p[63:0];
            step <= 1'b0;
            state <= S_ROOT;
          end
        end
        S_ROOT: begin
          root_start <= 1'b1;
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (root_done) begin
            len <= root;
            state <= S_ACCU;
          end
        end
        S_ACCU, S_ACCV: begin
          if (!step) begin
            prod_reg <= mul_p[63:0];
            step <= 1'b1;
          end else begin
            step <= 1'b0;
            if (state == S_ACCU) begin
              wsum_u <= sat_of(sat_sum);
              state <= S_ACCV;
            end else begin
              wsum_v <= sat_of(sat_sum);
              total_weight <= wsum[WEIGHT_W] ? '1 : wsum[WEIGHT_W-1:0];
              if (!last) begin
                state <= S_IDLE;
              end else if (!closing) begin
                a_u <= cur_u; a_v <= cur_v; b_u <= first_u; b_v <= first_v;
                closing <= 1'b1;
                state <= S_SQ;
              end else begin
                phase <= 2'd0;
                state <= S_DIV;
              end
            end
          end
        end
        S_DIV: begin
          if (total_weight == '0) begin
            out_u <= '0; out_v <= '0;
            deg <= 1'b1;
            state <= S_OUT;
          end else begin
            div_start <= 1'b1;
            unique case (phase)
              2'd0: begin div_n <= wsum_u; div_d <= total_weight; end
              2'd2: begin div_n <= wsum_v; div_d <= total_weight; end
              default: begin
                div_n <= 64'(mean_c) <<< FRACTION_BITS;
                div_d <= (asp_sel == '0) ? 48'd1 : 48'(asp_sel);
              end
            endcase
            state <= S_DWAIT;
          end
        end
        S_DWAIT: begin
          if (div_done) begin
            if (phase[0]) begin
              if (phase[1]) out_v <= COORD_W'(cen_c);
              else out_u <= COORD_W'(cen_c);
            end else begin
              div_n <= 64'(mean_c);
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // mean held in div_n between the two passes
          if (!phase[0]) begin
            div_start <= 1'b1;
            div_d <= (asp_sel == '0) ? 48'd1 : 48'(asp_sel);
            div_n <= div_n <<< FRACTION_BITS;
            phase <= phase + 2'd1;
            state <= S_DWAIT;
          end else if (phase == 2'd1) begin
            phase <= 2'd2;
            state <= S_DIV;
          end else begin
            deg <= 1'b0;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata <= {out_v, out_u};
            m_tuser <= deg;
            vertex_count <= '0;
            first_u <= '0; first_v <= '0; previous_u <= '0; previous_v <= '0;
            wsum_u <= '0; wsum_v <= '0; total_weight <= '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign s_tready = (state == S_IDLE);
endmodule
`default_nettype wire

// ===== dv/tb_polygon_edge_weighted_centroid_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_polygon_edge_weighted_centroid_unit: self-checking bench for the centroid unit
// Streams polygon rings under random idling and several aspect settings; a
// scoreboard predicts each ring's center and checks every result in order.
// ----------------------------------------------------------------------------

class centroid_scoreboard;
  logic [19:0] asp_u, asp_v;
  longint fu, fv, pu, pv, su, sv;
  longint unsigned tw;
  int vcnt;
  logic [48:0] exp_q[$];
  int errors;

  function new();
    asp_u = 20'd65536;
    asp_v = 20'd65536;
    errors = 0;
    clear();
  endfunction

  function void clear();
    fu = 0; fv = 0; pu = 0; pv = 0; su = 0; sv = 0; tw = 0; vcnt = 0;
  endfunction

  function longint floor_sh(longint x);
    return x >>> 16;  // arithmetic shift is floor division
  endfunction

  function longint unsigned isqrt(longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function longint sat_add(longint a, longint b);
    longint r;
    r = a + b;
    if (b > 0 && r < a) return 64'sh7fffffffffffffff;
    if (b < 0 && r > a) return 64'sh8000000000000000;
    return r;
  endfunction

  function void add_edge(longint au, longint av, longint bu, longint bv);
    longint du, dv, len;
    longint unsigned sq;
    du = au - bu;
    dv = av - bv;
    sq = du * du + dv * dv;
    len = isqrt(sq);
    su = sat_add(su, len * (au + bu));
    sv = sat_add(sv, len * (av + bv));
    tw = tw + 2 * len;
    if (tw > 64'hffffffffffff) tw = 64'hffffffffffff;
  endfunction

  function logic [23:0] finish(longint sum, logic [19:0] asp);
    longint mean, c, a;
    mean = sum / longint'(tw);
    if (mean > (64'sd1 <<< 36)) mean = 64'sd1 <<< 36;
    if (mean < -(64'sd1 <<< 36)) mean = -(64'sd1 <<< 36);
    a = (asp == 0) ? 1 : longint'(asp);
    c = (mean * 65536) / a;
    if (c > 8388607) c = 8388607;
    if (c < -8388608) c = -8388608;
    return c[23:0];
  endfunction

  // note one accepted vertex request
  function void note_vertex(logic [23:0] cu, logic [23:0] cv, logic last);
    longint u, v;
    u = floor_sh(longint'($signed(cu)) * longint'(asp_u));
    v = floor_sh(longint'($signed(cv)) * longint'(asp_v));
    if (vcnt == 0) begin
      fu = u; fv = v;
    end else begin
      add_edge(pu, pv, u, v);
    end
    pu = u; pv = v;
    if (vcnt < 1024) vcnt++;
    if (last) begin
      add_edge(u, v, fu, fv);
      if (tw == 0) exp_q.push_back({1'b1, 48'd0});
      else exp_q.push_back({1'b0, finish(sv, asp_v), finish(su, asp_u)});
      clear();
    end
  endfunction

  function void check_center(logic [47:0] d, logic deg);
    logic [48:0] e;
    if (exp_q.size() == 0) begin
      $display("%0t: unexpected result data=%h deg=%b", $time, d, deg);
      errors++;
      return;
    end
    e = exp_q.pop_front();
    if (d[23:0] !== e[23:0]) begin
      $display("%0t: center_u exp %h got %h", $time, e[23:0], d[23:0]);
      errors++;
    end
    if (d[47:24] !== e[47:24]) begin
      $display("%0t: center_v exp %h got %h", $time, e[47:24], d[47:24]);
      errors++;
    end
    if (deg !== e[48]) begin
      $display("%0t: degenerate exp %b got %b", $time, e[48], deg);
      errors++;
    end
  endfunction
endclass

module tb_polygon_edge_weighted_centroid_unit;
  import pewc_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [47:0] s_tdata = '0;  // coord_u[23:0], coord_v[47:24]
  logic s_tlast = 1'b0;       // last_vertex
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [47:0] m_tdata;       // center_u[23:0], center_v[47:24]
  logic m_tuser;              // degenerate
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = REG_ASPECT_U;
  logic [19:0] cfg_data = '0;

  int src_idle = 6;   // percent of cycles the sender holds off
  int sink_idle = 66; // percent of cycles the receiver stalls
  int stall_cnt = 0;
  centroid_scoreboard sb;

  always #5 clk = ~clk;

  polygon_edge_weighted_centroid_unit i_dut (.*);

  // receiver: random backpressure, checks every accepted result
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_center(m_tdata, m_tuser);
      m_tready <= ($urandom_range(99) >= sink_idle);
    end
  end

  // watchdog: cycles with no handshake on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt > 20000) begin
      $display("tb_polygon_edge_weighted_centroid_unit NOT OK");
      $finish;
    end
  end

  // tvalid stays high after acceptance unless the next request idles first
  task automatic send_vertex(logic [23:0] cu, logic [23:0] cv, logic last);
    while ($urandom_range(99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {cv, cu};
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_vertex(cu, cv, last);
  endtask

  // wait until all results are in, then let the block settle
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.exp_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_aspect(logic [0:0] idx, logic [19:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_ASPECT_U) sb.asp_u = val;
    else sb.asp_v = val;
    @(posedge clk);
  endtask

  function automatic logic [23:0] rand_coord();
    case ($urandom_range(5))
      0: return 24'h7fffff;
      1: return 24'h800000;
      2: return 24'($urandom_range(511)) - 24'd256;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [19:0] rand_aspect();
    case ($urandom_range(3))
      0: return 20'd65536;
      1: return 20'd1;
      2: return 20'hfffff;
      default: return 20'($urandom_range(20'hfffff, 1));
    endcase
  endfunction

  // random rings: mostly short, a few long
  task automatic random_rings(int items);
    int n, len;
    logic [23:0] cu, cv;
    n = 0;
    while (n < items) begin
      len = ($urandom_range(19) == 0) ? $urandom_range(1100, 40) : $urandom_range(8, 1);
      if (len > items - n) len = items - n;
      cu = rand_coord();
      cv = rand_coord();
      for (int k = 0; k < len; k++) begin
        // occasional repeat of the previous vertex gives zero-length edges
        if ($urandom_range(9) != 0) begin
          cu = rand_coord();
          cv = rand_coord();
        end
        send_vertex(cu, cv, k == len - 1);
      end
      n += len;
    end
  endtask

  initial begin
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: single vertex, coincident ring, extremes, unit square, two-vertex ring
    send_vertex(24'h123456, 24'hfedcba, 1'b1);
    send_vertex(24'h000100, 24'h000100, 1'b0);
    send_vertex(24'h000100, 24'h000100, 1'b1);
    send_vertex(24'h7fffff, 24'h7fffff, 1'b0);
    send_vertex(24'h800000, 24'h800000, 1'b0);
    send_vertex(24'h7fffff, 24'h800000, 1'b1);
    send_vertex(24'h000000, 24'h000000, 1'b0);
    send_vertex(24'h010000, 24'h000000, 1'b0);
    send_vertex(24'h010000, 24'h010000, 1'b0);
    send_vertex(24'h000000, 24'h010000, 1'b1);
    send_vertex(24'hffffff, 24'h000000, 1'b0);
    send_vertex(24'h000000, 24'hffffff, 1'b1);
    drain();

    // directed: aspect extremes
    write_aspect(REG_ASPECT_U, 20'hfffff);
    write_aspect(REG_ASPECT_V, 20'd1);
    send_vertex(24'h7fffff, 24'h7fffff, 1'b0);
    send_vertex(24'h800000, 24'h800000, 1'b0);
    send_vertex(24'h000000, 24'h400000, 1'b1);
    send_vertex(24'h000001, 24'h000001, 1'b0);
    send_vertex(24'hffffff, 24'hffffff, 1'b1);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        src_idle = 66; sink_idle = 6;
      end else if (ph == 2) begin
        src_idle = 0; sink_idle = 0;
      end
      write_aspect(REG_ASPECT_U, rand_aspect());
      write_aspect(REG_ASPECT_V, rand_aspect());
      random_rings(275);
      drain();
      write_aspect(REG_ASPECT_U, 20'd65536);
      write_aspect(REG_ASPECT_V, 20'($urandom_range(20'hfffff, 1)));
      random_rings(275);
      drain();
    end

    if (sb.errors == 0) $display("tb_polygon_edge_weighted_centroid_unit OK");
    else $display("tb_polygon_edge_weighted_centroid_unit NOT OK");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/pewc_pkg.sv
rtl/pewc_isqrt.sv
rtl/pewc_divider.sv
rtl/polygon_edge_weighted_centroid_unit.sv
dv/tb_polygon_edge_weighted_centroid_unit.sv
